/* rtl/tcb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcb_pkg
// Shared constants, codes and types of the text cell buffer writer.
// ----------------------------------------------------------------------------
package tcb_pkg;

	localparam int BUFFER_CELLS = 16384;
	localparam int CELL_AW      = $clog2(BUFFER_CELLS);
	localparam int DIRTY_W      = $clog2(BUFFER_CELLS + 1);
	localparam int ADDR_W       = 16;
	localparam int IDX_W        = 14;
	localparam int ROW_W        = 7;
	localparam int COL_W        = 8;
	localparam int COLOR_W      = 4;
	localparam int CHAR_W       = 8;
	localparam int ATTR_W       = 8;
	localparam int WORD_W       = 16;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 8;

	typedef enum logic [2:0] {
		REQ_PUT       = 3'd0,
		REQ_ERASE_EOL = 3'd1,
		REQ_MOVE      = 3'd2,
		REQ_FLUSH     = 3'd3,
		REQ_REVERSE   = 3'd4,
		REQ_FG        = 3'd5,
		REQ_BG        = 3'd6,
		REQ_READ      = 3'd7
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCREEN_COLS  = 3'd0,
		CFG_ROW_ORIGIN   = 3'd1,
		CFG_COL_ORIGIN   = 3'd2,
		CFG_VISIBLE_COLS = 3'd3,
		CFG_MONO_MODE    = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_ERASE,
		ST_RDATA
	} state_t;

	localparam logic RPT_FLUSH = 1'b0;
	localparam logic RPT_CELL  = 1'b1;

	localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;

	localparam logic [ATTR_W-1:0]  ATTR_RESET = 8'h07;
	localparam logic [COLOR_W-1:0] MONO_FG    = 4'h7;
	localparam logic [COLOR_W-1:0] MONO_BG    = 4'h0;

	localparam logic [7:0] SCREEN_COLS_RESET  = 8'd80;
	localparam logic [7:0] VISIBLE_COLS_RESET = 8'd80;

	localparam logic [COLOR_W-1:0] ANSI_MAP [16] = '{
		4'd0, 4'd4, 4'd2, 4'd6, 4'd1, 4'd5, 4'd3, 4'd7,
		4'd8, 4'd12, 4'd10, 4'd14, 4'd9, 4'd13, 4'd11, 4'd15
	};

	function automatic logic [COLOR_W-1:0] ansi_to_adapter(input logic [COLOR_W-1:0] color);
		return ANSI_MAP[color];
	endfunction

	typedef struct packed {
		logic               we;
		logic [CELL_AW-1:0] idx;
		logic               clear;
	} dirty_ctl_t;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] first;
		logic [IDX_W-1:0] last;
	} dirty_rpt_t;

	typedef struct packed {
		logic               set_rev;
		logic               rev;
		logic               set_fg;
		logic               set_bg;
		logic [COLOR_W-1:0] color;
		logic               mono;
	} attr_ctl_t;

endpackage

/* rtl/tcb_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcb_if
// Request and report channels: valid/ready handshake with item payload.
// ----------------------------------------------------------------------------
interface tcb_req_if;
	logic                        valid;
	logic                        ready;
	logic [2:0]                  req_type;
	logic [tcb_pkg::CHAR_W-1:0]  char_code;
	logic [tcb_pkg::ROW_W-1:0]   row;
	logic [tcb_pkg::COL_W-1:0]   col;
	logic [tcb_pkg::COLOR_W-1:0] color;
	logic                        reverse_on;
	logic [tcb_pkg::IDX_W-1:0]   cell_index;

	modport source (
		output valid, req_type, char_code, row, col, color, reverse_on, cell_index,
		input  ready
	);
	modport sink (
		input  valid, req_type, char_code, row, col, color, reverse_on, cell_index,
		output ready
	);
endinterface

interface tcb_rpt_if;
	logic                       valid;
	logic                       ready;
	logic                       report_kind;
	logic                       range_valid;
	logic [tcb_pkg::IDX_W-1:0]  first_index;
	logic [tcb_pkg::IDX_W-1:0]  last_index;
	logic [tcb_pkg::ROW_W-1:0]  cursor_row_out;
	logic [tcb_pkg::COL_W-1:0]  cursor_col_out;
	logic [tcb_pkg::WORD_W-1:0] cell_word;

	modport source (
		output valid, report_kind, range_valid, first_index, last_index,
		       cursor_row_out, cursor_col_out, cell_word,
		input  ready
	);
	modport sink (
		input  valid, report_kind, range_valid, first_index, last_index,
		       cursor_row_out, cursor_col_out, cell_word,
		output ready
	);
endinterface

/* rtl/text_cell_buffer_writer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_cell_buffer_writer
// Text-mode cell store writer with cursor, attributes and dirty range.
// ----------------------------------------------------------------------------
// Requests arrive on req (valid/ready), one item at a time. Reports leave on
// rpt: a flush gives the dirty range and cursor, a cell read gives the cell
// word and cursor; all other requests give no report.
// An item is taken in one cycle and executed in the next. Erase to end of
// line then writes one cell per cycle, bounded by the single write port of
// the cell RAM. A cell read waits in a data state for the registered RAM
// read data. The row base (row times stride) is registered when the item is
// taken.
// Reports sit in an output register; while the receiver stalls, a new item
// can still be taken, and only a flush or read that has to deliver waits.
// Config writes on cfg_we/cfg_idx/cfg_wdata are taken any cycle, and must
// come while the block is idle.
// Reset: cursor to 0,0, attributes 0x07, dirty range empty, stride and
// visible columns 80. Cell contents are undefined until written.
// ----------------------------------------------------------------------------
module text_cell_buffer_writer (
	input  logic                           clk,
	input  logic                           arst_n,
	tcb_req_if.sink                        req,
	tcb_rpt_if.source                      rpt,
	input  logic                           cfg_we,
	input  logic [tcb_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [tcb_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	localparam int AW = tcb_pkg::ADDR_W;
	localparam logic [AW-1:0] CELLS = AW'(tcb_pkg::BUFFER_CELLS);

	// configuration
	logic [7:0]                screen_cols_q;
	logic [tcb_pkg::ROW_W-1:0] row_origin_q;
	logic [tcb_pkg::COL_W-1:0] col_origin_q;
	logic [7:0]                visible_cols_q;
	logic                      mono_q;

	tcb_pkg::state_t state_q, state_d;

	// captured item
	tcb_pkg::req_t               req_type_q;
	logic [tcb_pkg::CHAR_W-1:0]  char_q;
	logic [tcb_pkg::ROW_W-1:0]   row_q;
	logic [tcb_pkg::COL_W-1:0]   col_q;
	logic [tcb_pkg::COLOR_W-1:0] color_q;
	logic                        rev_q;
	logic [tcb_pkg::IDX_W-1:0]   cidx_q;
	logic [AW-1:0]               base_s1;

	logic [tcb_pkg::ROW_W-1:0] cursor_row_q;
	logic [tcb_pkg::COL_W-1:0] cursor_col_q;
	logic [AW-1:0]             erase_idx_q;
	logic [AW-1:0]             erase_end_q;
	logic                      rd_in_range_q;

	logic                                  accept;
	logic [tcb_pkg::ROW_W+8-1:0]           row_prod;
	logic [tcb_pkg::COL_W-1:0]             bs_col;
	logic                                  out_free;
	logic                                  wr_req;
	logic                                  wr_ok;
	logic [AW-1:0]                         wr_addr;
	logic [tcb_pkg::CHAR_W-1:0]            wr_char;
	logic                                  row_we;
	logic [tcb_pkg::ROW_W-1:0]             row_d;
	logic                                  col_we;
	logic [tcb_pkg::COL_W-1:0]             col_d;
	logic                                  erase_start;
	logic                                  flush_clear;
	logic                                  rd_en;
	logic [AW-1:0]                         rd_addr;
	logic                                  rpt_load;
	logic                                  rpt_kind_d;
	logic [tcb_pkg::WORD_W-1:0]            rd_data;
	logic [tcb_pkg::ATTR_W-1:0]            attr;
	tcb_pkg::dirty_ctl_t                   dirty_ctl;
	tcb_pkg::dirty_rpt_t                   dirty_rpt;
	tcb_pkg::attr_ctl_t                    attr_ctl;

	logic                       rpt_valid_q;
	logic                       rpt_kind_q;
	logic                       rpt_range_q;
	logic [tcb_pkg::IDX_W-1:0]  rpt_first_q;
	logic [tcb_pkg::IDX_W-1:0]  rpt_last_q;
	logic [tcb_pkg::ROW_W-1:0]  rpt_row_q;
	logic [tcb_pkg::COL_W-1:0]  rpt_col_q;
	logic [tcb_pkg::WORD_W-1:0] rpt_word_q;

	assign req.ready = (state_q == tcb_pkg::ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign row_prod  = cursor_row_q * screen_cols_q;
	assign out_free  = !rpt_valid_q || rpt.ready;
	assign bs_col    = (cursor_col_q == '0) ? '0 : cursor_col_q - 1'b1;
	assign rd_addr   = AW'(cidx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_cols_q  <= tcb_pkg::SCREEN_COLS_RESET;
			row_origin_q   <= '0;
			col_origin_q   <= '0;
			visible_cols_q <= tcb_pkg::VISIBLE_COLS_RESET;
			mono_q         <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				tcb_pkg::CFG_SCREEN_COLS: begin
					screen_cols_q <= cfg_wdata;
				end
				tcb_pkg::CFG_ROW_ORIGIN: begin
					row_origin_q <= cfg_wdata[tcb_pkg::ROW_W-1:0];
				end
				tcb_pkg::CFG_COL_ORIGIN: begin
					col_origin_q <= cfg_wdata;
				end
				tcb_pkg::CFG_VISIBLE_COLS: begin
					visible_cols_q <= cfg_wdata;
				end
				tcb_pkg::CFG_MONO_MODE: begin
					mono_q <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// item capture; row base is latched here while the cursor is settled
	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q <= tcb_pkg::req_t'(req.req_type);
			char_q     <= req.char_code;
			row_q      <= req.row;
			col_q      <= req.col;
			color_q    <= req.color;
			rev_q      <= req.reverse_on;
			cidx_q     <= req.cell_index;
			base_s1    <= AW'(row_prod);
		end
	end

	always_comb begin
		state_d     = state_q;
		wr_req      = 1'b0;
		wr_addr     = erase_idx_q;
		wr_char     = tcb_pkg::CHAR_BLANK;
		row_we      = 1'b0;
		row_d       = row_q + row_origin_q;
		col_we      = 1'b0;
		col_d       = col_q + col_origin_q;
		erase_start = 1'b0;
		flush_clear = 1'b0;
		rd_en       = 1'b0;
		rpt_load    = 1'b0;
		rpt_kind_d  = tcb_pkg::RPT_FLUSH;
		attr_ctl    = '0;
		attr_ctl.color = color_q;
		attr_ctl.rev   = rev_q;
		attr_ctl.mono  = mono_q;
		case (state_q)
			tcb_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = tcb_pkg::ST_EXEC;
				end
			end
			tcb_pkg::ST_EXEC: begin
				state_d = tcb_pkg::ST_IDLE;
				case (req_type_q)
					tcb_pkg::REQ_PUT: begin
						if (char_q == tcb_pkg::CHAR_BS) begin
							wr_req  = 1'b1;
							wr_addr = base_s1 + AW'(bs_col);
							col_we  = 1'b1;
							col_d   = bs_col;
						end else if (char_q != tcb_pkg::CHAR_LF &&
						             char_q != tcb_pkg::CHAR_CR) begin
							wr_req  = 1'b1;
							wr_addr = base_s1 + AW'(cursor_col_q);
							wr_char = char_q;
							col_we  = 1'b1;
							col_d   = cursor_col_q + 1'b1;
						end
					end
					tcb_pkg::REQ_ERASE_EOL: begin
						erase_start = 1'b1;
						state_d     = tcb_pkg::ST_ERASE;
					end
					tcb_pkg::REQ_MOVE: begin
						row_we = 1'b1;
						col_we = 1'b1;
					end
					tcb_pkg::REQ_FLUSH: begin
						if (out_free) begin
							rpt_load    = 1'b1;
							rpt_kind_d  = tcb_pkg::RPT_FLUSH;
							flush_clear = 1'b1;
						end else begin
							state_d = tcb_pkg::ST_EXEC;
						end
					end
					tcb_pkg::REQ_REVERSE: begin
						attr_ctl.set_rev = 1'b1;
					end
					tcb_pkg::REQ_FG: begin
						attr_ctl.set_fg = 1'b1;
					end
					tcb_pkg::REQ_BG: begin
						attr_ctl.set_bg = 1'b1;
					end
					tcb_pkg::REQ_READ: begin
						rd_en   = 1'b1;
						state_d = tcb_pkg::ST_RDATA;
					end
					default: begin
					end
				endcase
			end
			tcb_pkg::ST_ERASE: begin
				// cells past the store end are dropped, so stop there too
				if (erase_idx_q < erase_end_q && erase_idx_q < CELLS) begin
					wr_req = 1'b1;
				end else begin
					state_d = tcb_pkg::ST_IDLE;
				end
			end
			tcb_pkg::ST_RDATA: begin
				if (out_free) begin
					rpt_load   = 1'b1;
					rpt_kind_d = tcb_pkg::RPT_CELL;
					state_d    = tcb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tcb_pkg::ST_IDLE;
			end
		endcase
	end

	assign wr_ok     = wr_req && (wr_addr < CELLS);
	assign dirty_ctl = '{
		we:    wr_ok,
		idx:   wr_addr[tcb_pkg::CELL_AW-1:0],
		clear: flush_clear
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_row_q <= '0;
			cursor_col_q <= '0;
		end else begin
			if (row_we) begin
				cursor_row_q <= row_d;
			end
			if (col_we) begin
				cursor_col_q <= col_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (erase_start) begin
			erase_idx_q <= base_s1 + AW'(cursor_col_q);
			erase_end_q <= base_s1 + AW'(visible_cols_q) + AW'(col_origin_q);
		end else if (wr_req && state_q == tcb_pkg::ST_ERASE) begin
			erase_idx_q <= erase_idx_q + 1'b1;
		end
		if (rd_en) begin
			rd_in_range_q <= rd_addr < CELLS;
		end
	end

	tcb_cell_ram #(
		.WIDTH(tcb_pkg::WORD_W),
		.DEPTH(tcb_pkg::BUFFER_CELLS)
	) u_ram (
		.clk   (clk),
		.we    (wr_ok),
		.waddr (wr_addr[tcb_pkg::CELL_AW-1:0]),
		.wdata ({attr, wr_char}),
		.re    (rd_en),
		.raddr (rd_addr[tcb_pkg::CELL_AW-1:0]),
		.rdata (rd_data)
	);

	tcb_dirty u_dirty (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (dirty_ctl),
		.rpt    (dirty_rpt)
	);

	tcb_attr u_attr (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (attr_ctl),
		.attr   (attr)
	);

	// report output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_valid_q <= 1'b0;
		end else if (rpt_load) begin
			rpt_valid_q <= 1'b1;
		end else if (rpt.ready) begin
			rpt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rpt_load) begin
			rpt_kind_q <= rpt_kind_d;
			rpt_row_q  <= cursor_row_q;
			rpt_col_q  <= cursor_col_q;
			if (rpt_kind_d == tcb_pkg::RPT_CELL) begin
				rpt_range_q <= 1'b0;
				rpt_first_q <= '0;
				rpt_last_q  <= '0;
				rpt_word_q  <= rd_in_range_q ? rd_data : '0;
			end else begin
				rpt_range_q <= dirty_rpt.valid;
				rpt_first_q <= dirty_rpt.first;
				rpt_last_q  <= dirty_rpt.last;
				rpt_word_q  <= '0;
			end
		end
	end

	assign rpt.valid          = rpt_valid_q;
	assign rpt.report_kind    = rpt_kind_q;
	assign rpt.range_valid    = rpt_range_q;
	assign rpt.first_index    = rpt_first_q;
	assign rpt.last_index     = rpt_last_q;
	assign rpt.cursor_row_out = rpt_row_q;
	assign rpt.cursor_col_out = rpt_col_q;
	assign rpt.cell_word      = rpt_word_q;

`ifndef NO_ASSERTIONS
	a_read_to_rdata: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcb_pkg::ST_EXEC && req_type_q == tcb_pkg::REQ_READ)
		|=> state_q == tcb_pkg::ST_RDATA)
		else $error("cell read did not move on to the data stage");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		dirty_ctl.clear |=> !dirty_rpt.valid)
		else $error("dirty range not empty after flush");

	a_cursor_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != tcb_pkg::ST_EXEC) |=> ($stable(cursor_row_q) && $stable(cursor_col_q)))
		else $error("cursor changed outside item execution");
`endif

endmodule

/* rtl/tcb_cell_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcb_cell_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcb_cell_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/tcb_dirty.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcb_dirty
// Tracks the lowest and highest cell written since the last flush.
// ----------------------------------------------------------------------------
module tcb_dirty (
	input  logic                clk,
	input  logic                arst_n,
	input  tcb_pkg::dirty_ctl_t ctl,
	output tcb_pkg::dirty_rpt_t rpt
);

	logic [tcb_pkg::DIRTY_W-1:0] low_q;
	logic [tcb_pkg::CELL_AW-1:0] high_q;
	logic [tcb_pkg::ADDR_W-1:0]  low_ext;
	logic [tcb_pkg::ADDR_W-1:0]  high_ext;
	logic                        range_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= tcb_pkg::DIRTY_W'(tcb_pkg::BUFFER_CELLS);
			high_q <= '0;
		end else if (ctl.clear) begin
			low_q  <= tcb_pkg::DIRTY_W'(tcb_pkg::BUFFER_CELLS);
			high_q <= '0;
		end else if (ctl.we) begin
			if (tcb_pkg::DIRTY_W'(ctl.idx) < low_q) begin
				low_q <= tcb_pkg::DIRTY_W'(ctl.idx);
			end
			if (ctl.idx > high_q) begin
				high_q <= ctl.idx;
			end
		end
	end

	assign range_ok  = low_q <= tcb_pkg::DIRTY_W'(high_q);
	assign low_ext   = tcb_pkg::ADDR_W'(low_q);
	assign high_ext  = tcb_pkg::ADDR_W'(high_q);
	assign rpt.valid = range_ok;
	assign rpt.first = range_ok ? low_ext[tcb_pkg::IDX_W-1:0] : '0;
	assign rpt.last  = range_ok ? high_ext[tcb_pkg::IDX_W-1:0] : '0;

endmodule

/* rtl/tcb_attr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcb_attr
// Normal and reverse attribute registers with the colour mapping table.
// ----------------------------------------------------------------------------
module tcb_attr (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tcb_pkg::attr_ctl_t         ctl,
	output logic [tcb_pkg::ATTR_W-1:0] attr
);

	logic [tcb_pkg::ATTR_W-1:0]  normal_q;
	logic [tcb_pkg::ATTR_W-1:0]  reverse_q;
	logic                        rev_mode_q;
	logic [tcb_pkg::COLOR_W-1:0] fg_c;
	logic [tcb_pkg::COLOR_W-1:0] bg_c;

	assign fg_c = ctl.mono ? tcb_pkg::MONO_FG : tcb_pkg::ansi_to_adapter(ctl.color);
	assign bg_c = ctl.mono ? tcb_pkg::MONO_BG : tcb_pkg::ansi_to_adapter(ctl.color);

	// reverse attribute keeps foreground in the high nibble
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_q   <= tcb_pkg::ATTR_RESET;
			reverse_q  <= tcb_pkg::ATTR_RESET;
			rev_mode_q <= 1'b0;
		end else begin
			if (ctl.set_rev) begin
				rev_mode_q <= ctl.rev;
			end
			if (ctl.set_fg) begin
				normal_q  <= {normal_q[7:4], fg_c};
				reverse_q <= {fg_c, reverse_q[3:0]};
			end else if (ctl.set_bg) begin
				normal_q  <= {bg_c, normal_q[3:0]};
				reverse_q <= {reverse_q[7:4], bg_c};
			end
		end
	end

	assign attr = rev_mode_q ? reverse_q : normal_q;

endmodule

/* verif/tb_text_cell_buffer_writer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_cell_buffer_writer
// Self-checking bench for the text cell buffer writer. A short stimulus
// table runs first, then random request streams under several register
// settings. Every request is run through a local copy of the cell store,
// cursor, attributes and dirty range. Each flush or cell-read report is
// compared field by field with the oldest expected report.
// ----------------------------------------------------------------------------
module tb_text_cell_buffer_writer;

	localparam int DRAIN_CYCLES = 600;   // longest erase plus read latency
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 170;
	localparam int DIR_N        = 25;
	localparam int MAX_PRINTS   = 30;

	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_BLANK = 8'h20;
	localparam logic [3:0] MONO_FORE = 4'h7;
	localparam logic [3:0] MONO_BACK = 4'h0;

	localparam logic [3:0] COLOR_XLAT [16] = '{
		4'd0, 4'd4, 4'd2, 4'd6, 4'd1, 4'd5, 4'd3, 4'd7,
		4'd8, 4'd12, 4'd10, 4'd14, 4'd9, 4'd13, 4'd11, 4'd15
	};

	typedef struct packed {
		tcb_pkg::req_t kind;
		logic [7:0]    ch;
		logic [6:0]    row;
		logic [7:0]    col;
		logic [3:0]    color;
		logic          rev;
		logic [13:0]   idx;
	} req_item_t;

	typedef struct packed {
		logic        kind;
		logic        range_valid;
		logic [13:0] first_idx;
		logic [13:0] last_idx;
		logic [6:0]  row;
		logic [7:0]  col;
		logic [15:0] word;
	} rpt_item_t;

	// arg: char, row, color, reverse flag or cell index; arg2: move column
	typedef struct packed {
		tcb_pkg::req_t kind;
		logic [13:0]   arg;
		logic [7:0]    arg2;
		logic          typed;
		rpt_item_t     res;
	} dir_row_t;

	localparam rpt_item_t NO_RPT = '0;

	localparam dir_row_t DIR_TAB [DIR_N] = '{
		'{tcb_pkg::REQ_FLUSH,     14'd0,     8'd0,   1'b1,
			'{tcb_pkg::RPT_FLUSH, 1'b0, 14'd0, 14'd0, 7'd0, 8'd0, 16'h0000}},
		'{tcb_pkg::REQ_PUT,       14'h41,    8'd0,   1'b0, NO_RPT},
		'{tcb_pkg::REQ_READ,      14'd0,     8'd0,   1'b1,
			'{tcb_pkg::RPT_CELL, 1'b0, 14'd0, 14'd0, 7'd0, 8'd1, 16'h0741}},
		'{tcb_pkg::REQ_PUT,       14'hFF,    8'd0,   1'b0, NO_RPT},
		'{tcb_pkg::REQ_PUT,       14'h0A,    8'd0,   1'b0, NO_RPT},
		'{tcb_pkg::REQ_PUT,       14'h0D,    8'd0,   1'b0, NO_RPT},
		'{tcb_pkg::REQ_PUT,       14'h08,    8'd0,   1'b0, NO_RPT},
		'{tcb_pkg::REQ_READ,      14'd1,     8'd0,   1'b1,
			'{tcb_pkg::RPT_CELL, 1'b0, 14'd0, 14'd0, 7'd0, 8'd1, 16'h0720}},
		'{tcb_pkg::REQ_FLUSH,     14'd0,     8'd0,   1'b1,
			'{tcb_pkg::RPT_FLUSH, 1'b1, 14'd0, 14'd1, 7'd0, 8'd1, 16'h0000}},
		'{tcb_pkg::REQ_MOVE,      14'd0,     8'd0,   1'b0, NO_RPT},
		'{tcb_pkg::REQ_PUT,       14'h08,    8'd0,   1'b0, NO_RPT},
		'{tcb_pkg::REQ_READ,      14'd0,     8'd0,   1'b1,
			'{tcb_pkg::RPT_CELL, 1'b0, 14'd0, 14'd0, 7'd0, 8'd0, 16'h0720}},
		'{tcb_pkg::REQ_FG,        14'd15,    8'd0,   1'b0, NO_RPT},
		'{tcb_pkg::REQ_BG,        14'd1,     8'd0,   1'b0, NO_RPT},
		'{tcb_pkg::REQ_REVERSE,   14'd1,     8'd0,   1'b0, NO_RPT},
		'{tcb_pkg::REQ_PUT,       14'h7A,    8'd0,   1'b0, NO_RPT},
		'{tcb_pkg::REQ_READ,      14'd0,     8'd0,   1'b0, NO_RPT},
		'{tcb_pkg::REQ_REVERSE,   14'd0,     8'd0,   1'b0, NO_RPT},
		'{tcb_pkg::REQ_MOVE,      14'd0,     8'd200, 1'b0, NO_RPT},
		'{tcb_pkg::REQ_ERASE_EOL, 14'd0,     8'd0,   1'b0, NO_RPT},
		'{tcb_pkg::REQ_MOVE,      14'd127,   8'd255, 1'b0, NO_RPT},
		'{tcb_pkg::REQ_PUT,       14'h78,    8'd0,   1'b0, NO_RPT},
		'{tcb_pkg::REQ_ERASE_EOL, 14'd0,     8'd0,   1'b0, NO_RPT},
		'{tcb_pkg::REQ_READ,      14'd10415, 8'd0,   1'b0, NO_RPT},
		'{tcb_pkg::REQ_FLUSH,     14'd0,     8'd0,   1'b0, NO_RPT}
	};

	// screen_cols, row_origin, col_origin, visible_cols, mono_mode
	localparam logic [7:0] PHASE_CFG [5][5] = '{
		'{8'd80,  8'd0,   8'd0,   8'd80,  8'd0},
		'{8'd1,   8'd0,   8'd0,   8'd1,   8'd0},
		'{8'd255, 8'd127, 8'd255, 8'd255, 8'd1},
		'{8'd255, 8'd0,   8'd0,   8'd255, 8'd0},
		'{8'd37,  8'd3,   8'd200, 8'd12,  8'd1}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [tcb_pkg::CFG_IDX_W-1:0]  cfg_idx;
	logic [tcb_pkg::CFG_DATA_W-1:0] cfg_wdata;
	bit   take_rpt;
	bit   steady;

	tcb_req_if req_ch ();
	tcb_rpt_if rpt_ch ();

	assign rpt_ch.ready = take_rpt;

	text_cell_buffer_writer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rpt       (rpt_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// local copy of the block state
	logic [15:0] cells [tcb_pkg::BUFFER_CELLS];
	bit          cell_known [tcb_pkg::BUFFER_CELLS];
	int          known_idx [$];
	logic [6:0]  cur_row;
	logic [7:0]  cur_col;
	int          dirty_lo;
	int          dirty_hi;
	logic [7:0]  norm_attr;
	logic [7:0]  rev_attr;
	logic        rev_mode;
	logic [7:0]  stride;
	logic [6:0]  row_org;
	logic [7:0]  col_org;
	logic [7:0]  vis_cols;
	logic        mono;

	rpt_item_t reports_due [$];
	int err_cnt;
	int n_req;
	int n_flush;
	int n_read;
	int n_dropped;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#10_000_000;
		$display("%0t timeout, %0d reports still due", $time, reports_due.size());
		$display("tb_text_cell_buffer_writer: FAIL");
		$finish;
	end

	function automatic void write_cell(int idx, logic [15:0] w);
		if (idx >= tcb_pkg::BUFFER_CELLS) begin
			n_dropped++;
			return;
		end
		cells[idx] = w;
		if (!cell_known[idx]) begin
			cell_known[idx] = 1'b1;
			known_idx.push_back(idx);
		end
		if (idx < dirty_lo)
			dirty_lo = idx;
		if (idx > dirty_hi)
			dirty_hi = idx;
	endfunction

	// Applies one request to the local state; returns 1 with the report
	// when the request produces one.
	function automatic bit run_request(input req_item_t it, output rpt_item_t r);
		int base;
		int idx;
		int stop;
		logic [7:0] attr;
		logic [3:0] clr;
		base = int'(cur_row) * int'(stride);
		attr = rev_mode ? rev_attr : norm_attr;
		r = '0;
		case (it.kind)
			tcb_pkg::REQ_PUT: begin
				if (it.ch == CH_LF || it.ch == CH_CR)
					return 1'b0;
				if (it.ch == CH_BS) begin
					if (cur_col != 8'd0)
						cur_col = cur_col - 8'd1;
					write_cell(base + int'(cur_col), {attr, CH_BLANK});
				end else begin
					write_cell(base + int'(cur_col), {attr, it.ch});
					cur_col = cur_col + 8'd1;
				end
				return 1'b0;
			end
			tcb_pkg::REQ_ERASE_EOL: begin
				stop = base + int'(vis_cols) + int'(col_org);
				for (idx = base + int'(cur_col); idx < stop; idx++)
					write_cell(idx, {attr, CH_BLANK});
				return 1'b0;
			end
			tcb_pkg::REQ_MOVE: begin
				cur_row = it.row + row_org;
				cur_col = it.col + col_org;
				return 1'b0;
			end
			tcb_pkg::REQ_REVERSE: begin
				rev_mode = it.rev;
				return 1'b0;
			end
			tcb_pkg::REQ_FG: begin
				clr = mono ? MONO_FORE : COLOR_XLAT[it.color];
				norm_attr = {norm_attr[7:4], clr};
				rev_attr = {clr, rev_attr[3:0]};
				return 1'b0;
			end
			tcb_pkg::REQ_BG: begin
				clr = mono ? MONO_BACK : COLOR_XLAT[it.color];
				norm_attr = {clr, norm_attr[3:0]};
				rev_attr = {rev_attr[7:4], clr};
				return 1'b0;
			end
			tcb_pkg::REQ_FLUSH: begin
				r.kind = tcb_pkg::RPT_FLUSH;
				if (dirty_lo <= dirty_hi) begin
					r.range_valid = 1'b1;
					r.first_idx = dirty_lo[13:0];
					r.last_idx = dirty_hi[13:0];
				end
				dirty_lo = tcb_pkg::BUFFER_CELLS;
				dirty_hi = 0;
			end
			default: begin
				r.kind = tcb_pkg::RPT_CELL;
				r.word = cells[it.idx];
			end
		endcase
		r.row = cur_row;
		r.col = cur_col;
		return 1'b1;
	endfunction

	function automatic req_item_t rand_req();
		req_item_t it;
		int pick;
		it.ch = 8'($urandom_range(255));
		it.row = 7'($urandom_range(127));
		it.col = 8'($urandom_range(255));
		it.color = 4'($urandom_range(15));
		it.rev = 1'($urandom_range(1));
		it.idx = 14'($urandom_range(16383));
		pick = $urandom_range(99);
		if (pick < 45) begin
			it.kind = tcb_pkg::REQ_PUT;
			if ($urandom_range(9) == 0) begin
				case ($urandom_range(2))
					0: it.ch = CH_BS;
					1: it.ch = CH_LF;
					default: it.ch = CH_CR;
				endcase
			end
		end else if (pick < 53) begin
			it.kind = tcb_pkg::REQ_ERASE_EOL;
		end else if (pick < 65) begin
			it.kind = tcb_pkg::REQ_MOVE;
			// keep half the moves near the origin so rows get refilled
			if ($urandom_range(1)) begin
				it.row = 7'($urandom_range(3));
				it.col = 8'($urandom_range(15));
			end
		end else if (pick < 72) begin
			it.kind = tcb_pkg::REQ_FLUSH;
		end else if (pick < 77) begin
			it.kind = tcb_pkg::REQ_REVERSE;
		end else if (pick < 83) begin
			it.kind = tcb_pkg::REQ_FG;
		end else if (pick < 89) begin
			it.kind = tcb_pkg::REQ_BG;
		end else if (known_idx.size() == 0) begin
			it.kind = tcb_pkg::REQ_FLUSH;
		end else begin
			// reads only target cells that have been written
			it.kind = tcb_pkg::REQ_READ;
			it.idx = 14'(known_idx[$urandom_range(known_idx.size() - 1)]);
		end
		return it;
	endfunction

	function automatic void cmp_field(string name, int unsigned want,
		int unsigned got);
		if (want == got)
			return;
		err_cnt++;
		if (err_cnt <= MAX_PRINTS)
			$display("%0t report %s mismatch: expected %0h, got %0h",
				$time, name, want, got);
	endfunction

	task automatic check_report();
		rpt_item_t got;
		rpt_item_t want;
		got = {rpt_ch.report_kind, rpt_ch.range_valid, rpt_ch.first_index,
			rpt_ch.last_index, rpt_ch.cursor_row_out, rpt_ch.cursor_col_out,
			rpt_ch.cell_word};
		if (reports_due.size() == 0) begin
			err_cnt++;
			if (err_cnt <= MAX_PRINTS)
				$display("%0t unexpected report: expected none, got %h", $time, got);
			return;
		end
		want = reports_due.pop_front();
		if (want.kind == tcb_pkg::RPT_FLUSH)
			n_flush++;
		else
			n_read++;
		cmp_field("report_kind", want.kind, got.kind);
		cmp_field("range_valid", want.range_valid, got.range_valid);
		cmp_field("first_index", want.first_idx, got.first_idx);
		cmp_field("last_index", want.last_idx, got.last_idx);
		cmp_field("cursor_row_out", want.row, got.row);
		cmp_field("cursor_col_out", want.col, got.col);
		cmp_field("cell_word", want.word, got.word);
	endtask

	always @(posedge clk) begin
		if (arst_n && rpt_ch.valid && rpt_ch.ready)
			check_report();
		take_rpt <= steady || ($urandom_range(99) >= 26);
	end

	task automatic send_request(input req_item_t it, input bit typed, input rpt_item_t res);
		rpt_item_t r;
		while (!steady && $urandom_range(99) < 26) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= it.kind;
		req_ch.char_code  <= it.ch;
		req_ch.row        <= it.row;
		req_ch.col        <= it.col;
		req_ch.color      <= it.color;
		req_ch.reverse_on <= it.rev;
		req_ch.cell_index <= it.idx;
		do
			@(posedge clk);
		while (!req_ch.ready);
		n_req++;
		if (run_request(it, r))
			reports_due.push_back(typed ? res : r);
	endtask

	// Holds requests off until every report is in and any erase has ended.
	task automatic drain_reports();
		req_ch.valid <= 1'b0;
		while (reports_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input tcb_pkg::cfg_reg_t r, input logic [7:0] v);
		cfg_we    <= 1'b1;
		cfg_idx   <= r;
		cfg_wdata <= v;
		@(posedge clk);
		case (r)
			tcb_pkg::CFG_SCREEN_COLS:  stride = v;
			tcb_pkg::CFG_ROW_ORIGIN:   row_org = v[6:0];
			tcb_pkg::CFG_COL_ORIGIN:   col_org = v;
			tcb_pkg::CFG_VISIBLE_COLS: vis_cols = v;
			default:                   mono = v[0];
		endcase
	endtask

	initial begin
		req_item_t  it;
		dir_row_t   d;
		logic [7:0] cfg [5];

		arst_n            <= 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.req_type   <= tcb_pkg::REQ_PUT;
		req_ch.char_code  <= '0;
		req_ch.row        <= '0;
		req_ch.col        <= '0;
		req_ch.color      <= '0;
		req_ch.reverse_on <= 1'b0;
		req_ch.cell_index <= '0;
		cfg_we            <= 1'b0;
		cfg_idx           <= tcb_pkg::CFG_SCREEN_COLS;
		cfg_wdata         <= '0;

		cur_row   = '0;
		cur_col   = '0;
		dirty_lo  = tcb_pkg::BUFFER_CELLS;
		dirty_hi  = 0;
		norm_attr = 8'h07;
		rev_attr  = 8'h07;
		rev_mode  = 1'b0;
		stride    = 8'd80;
		row_org   = '0;
		col_org   = '0;
		vis_cols  = 8'd80;
		mono      = 1'b0;
		steady    = 1'b0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++) begin
			d = DIR_TAB[i];
			it = rand_req();
			it.kind = d.kind;
			case (d.kind)
				tcb_pkg::REQ_PUT:     it.ch = d.arg[7:0];
				tcb_pkg::REQ_MOVE: begin
					it.row = d.arg[6:0];
					it.col = d.arg2;
				end
				tcb_pkg::REQ_REVERSE: it.rev = d.arg[0];
				tcb_pkg::REQ_FG,
				tcb_pkg::REQ_BG:      it.color = d.arg[3:0];
				tcb_pkg::REQ_READ:    it.idx = d.arg;
				default: ;
			endcase
			send_request(it, d.typed, d.res);
		end
		drain_reports();

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph < PHASES - 1) begin
				cfg = PHASE_CFG[ph];
			end else begin
				cfg[0] = 8'($urandom_range(1, 255));
				cfg[1] = 8'($urandom_range(127));
				cfg[2] = 8'($urandom_range(255));
				cfg[3] = 8'($urandom_range(1, 255));
				cfg[4] = 8'($urandom_range(1));
			end
			write_reg(tcb_pkg::CFG_SCREEN_COLS, cfg[0]);
			write_reg(tcb_pkg::CFG_ROW_ORIGIN, cfg[1]);
			write_reg(tcb_pkg::CFG_COL_ORIGIN, cfg[2]);
			write_reg(tcb_pkg::CFG_VISIBLE_COLS, cfg[3]);
			write_reg(tcb_pkg::CFG_MONO_MODE, cfg[4]);
			cfg_we <= 1'b0;
			steady = (ph == 3);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2)
					drain_reports();
				send_request(rand_req(), 1'b0, NO_RPT);
			end
			drain_reports();
		end
		steady = 1'b0;

		$display("%0d requests over %0d register settings",
			n_req, PHASES + 1);
		$display("%0d flush and %0d cell-read reports checked, %0d cells written",
			n_flush, n_read, known_idx.size());
		$display("%0d writes fell outside the store, %0d mismatches",
			n_dropped, err_cnt);
		if (err_cnt == 0 && reports_due.size() == 0)
			$display("tb_text_cell_buffer_writer: PASS");
		else
			$display("tb_text_cell_buffer_writer: FAIL");
		$finish;
	end

endmodule
